/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implications, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/trs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_pkg
// Commands, controller states and port widths of the trace ring.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int S_DATA_W = 88;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 128;
    localparam int M_USER_W = 1;
    localparam int SLOPE_W  = 48;
    localparam int FRAC_W   = 32;
    localparam int FIELD_W  = 13;

    typedef enum logic [2:0] {
        CMD_RECORD = 3'd0,
        CMD_READ   = 3'd1,
        CMD_RECENT = 3'd2,
        CMD_SLOPE  = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* rtl/trace_ring_with_slope.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_ring_with_slope
// Ring of (stack pointer, cycle stamp) samples with reads and a
// least-squares slope over the newest samples.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tuser: command; tdata: sp, stamp, index,
//                                   limit, window
// m_        out  m_tvalid/m_tready  tuser: sample_valid; tdata: sp, cycles,
//                                   stored_count, recent_count, slope
// cfg_      in   cfg_valid/cfg_ready enable
//
// Record, read, recent, clear: one item per cycle while the output is not
// stalled; a result passes the p1 register, then the output register.
// Slope: window walk (one RAM read per cycle), four shift-add products (one
// multiplier bit per cycle), a restoring divide; no item is taken meanwhile.
// Reset clears pointer, count and enable; the sample RAM needs no clearing.
// A stalled result holds in the output register; one more item waits in p1.
// ----------------------------------------------------------------------------
module trace_ring_with_slope #(
    parameter int DEPTH = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] sp_value, [47:16] cycle_stamp, [59:48] sample_index,
    // [72:60] recent_limit, [85:73] window_length
    input  logic [trs_pkg::S_DATA_W-1:0]  s_tdata,
    // [2:0] command
    input  logic [trs_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] sample_sp, [47:16] sample_cycles, [60:48] stored_count,
    // [73:61] recent_count, [121:74] slope
    output logic [trs_pkg::M_DATA_W-1:0]  m_tdata,
    // [0] sample_valid
    output logic [trs_pkg::M_USER_W-1:0]  m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_data
);
    import trs_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int EW   = (CW > FIELD_W) ? CW + 1 : FIELD_W + 1;
    localparam int PSW  = CW + 1;
    localparam int SXW  = 33 + CW;
    localparam int SYW  = 16 + CW;
    localparam int SXXW = 64 + CW;
    localparam int SXYW = 50 + CW;
    localparam int WW   = 67 + 2 * CW;
    localparam int QW   = WW + FRAC_W;
    localparam int DCW  = $clog2(QW + 1);

    state_t state_reg, state_next;
    logic enable_reg, enable_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic p1_vld_reg, p1_vld_next, p1_rd_reg, p1_rd_next;
    logic [FIELD_W-1:0] p1_cnt_reg, p1_cnt_next, p1_rc_reg, p1_rc_next;

    logic m_vld_reg, m_vld_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [M_USER_W-1:0] m_user_reg, m_user_next;

    logic [CW-1:0] w_reg, w_next, start_reg, start_next, iss_reg, iss_next;
    logic rd_vld_reg, rd_vld_next, first_reg, first_next;
    logic [31:0] xref_reg, xref_next;
    logic b_vld_reg, b_vld_next, c_vld_reg, c_vld_next;
    logic signed [32:0] bx_reg, bx_next, cx_reg, cx_next;
    logic [31:0] bax_reg, bax_next;
    logic [15:0] by_reg, by_next, cy_reg, cy_next;
    logic [63:0] pxx_reg, pxx_next;
    logic signed [49:0] pxy_reg, pxy_next;
    logic signed [SXW-1:0] sx_reg, sx_next;
    logic [SYW-1:0] sy_reg, sy_next;
    logic [SXXW-1:0] sxx_reg, sxx_next;
    logic signed [SXYW-1:0] sxy_reg, sxy_next;

    logic [1:0] sel_reg, sel_next, sel_ld;
    logic [WW-1:0] ma_reg, ma_next, mb_reg, mb_next, macc_reg, macc_next;
    logic [WW-1:0] t_reg, t_next, den_reg, den_next, opa, opb;
    logic [SXW-1:0] sx_mag;
    logic neg_reg, neg_next;
    logic [QW-1:0] dvd_reg, dvd_next;
    logic [WW-1:0] rem_reg, rem_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic [SLOPE_W-1:0] slope_reg, slope_next;

    cmd_t cmd;
    logic out_free, p1_go, s_acc, full;
    logic ram_we, ram_re;
    logic [AW-1:0] ram_raddr;
    logic [47:0] ram_rdata;
    logic [CW-1:0] lin;
    logic [PSW-1:0] psum;

    assign cmd       = cmd_t'(s_tuser);
    assign out_free  = !m_vld_reg || m_tready;
    assign p1_go     = p1_vld_reg && out_free;
    assign s_tready  = (state_reg == ST_IDLE) && (!p1_vld_reg || out_free)
                       && !(cmd == CMD_SLOPE && p1_vld_reg);
    assign s_acc     = s_tvalid && s_tready;
    assign full      = (count_reg == CW'(DEPTH));
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_vld_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // oldest-first position to RAM address
    assign psum      = PSW'(wptr_reg) + PSW'(lin);
    assign ram_raddr = !full ? lin[AW-1:0] :
                       (psum >= PSW'(DEPTH)) ? AW'(psum - PSW'(DEPTH)) : psum[AW-1:0];

    // product operands: n*sxx, sx*sx, n*sxy, sx*sy
    assign sx_mag = sx_reg[SXW-1] ? SXW'(-sx_reg) : SXW'(sx_reg);
    assign sel_ld = (state_reg == ST_MUL) ? sel_reg + 2'd1 : 2'd0;
    always_comb begin
        case (sel_ld)
            2'd0: begin opa = WW'(sxx_reg); opb = WW'(w_reg);  end
            2'd1: begin opa = WW'(sx_mag);  opb = WW'(sx_mag); end
            2'd2: begin opa = WW'(sxy_reg); opb = WW'(w_reg);  end
            default: begin opa = WW'(sx_reg); opb = WW'(sy_reg); end
        endcase
    end

    trs_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata ({s_tdata[47:16], s_tdata[15:0]}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            enable_reg <= 1'b0;
            wptr_reg   <= '0;
            count_reg  <= '0;
            p1_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
            rd_vld_reg <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            enable_reg <= enable_next;
            wptr_reg   <= wptr_next;
            count_reg  <= count_next;
            p1_vld_reg <= p1_vld_next;
            m_vld_reg  <= m_vld_next;
            rd_vld_reg <= rd_vld_next;
            b_vld_reg  <= b_vld_next;
            c_vld_reg  <= c_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        p1_rd_reg  <= p1_rd_next;
        p1_cnt_reg <= p1_cnt_next;
        p1_rc_reg  <= p1_rc_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        w_reg      <= w_next;
        start_reg  <= start_next;
        iss_reg    <= iss_next;
        first_reg  <= first_next;
        xref_reg   <= xref_next;
        bx_reg     <= bx_next;
        bax_reg    <= bax_next;
        by_reg     <= by_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        pxx_reg    <= pxx_next;
        pxy_reg    <= pxy_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        sxx_reg    <= sxx_next;
        sxy_reg    <= sxy_next;
        sel_reg    <= sel_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        macc_reg   <= macc_next;
        t_reg      <= t_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        dcnt_reg   <= dcnt_next;
        slope_reg  <= slope_next;
    end

    always_comb begin
        logic [EW-1:0] idx_e, cnt_e, lim_e, wl_e, n_e, w_e, lin_e, cnt_nx_e;
        logic [31:0] rd_cyc, xr;
        logic signed [32:0] x_a;
        logic [WW-1:0] num_v, mag;
        logic [WW:0] rem_sh;
        logic ge, sat;
        logic [SLOPE_W-1:0] mag48;

        state_next  = state_reg;
        enable_next = enable_reg;
        wptr_next   = wptr_reg;
        count_next  = count_reg;
        p1_vld_next = p1_vld_reg;
        p1_rd_next  = p1_rd_reg;
        p1_cnt_next = p1_cnt_reg;
        p1_rc_next  = p1_rc_reg;
        m_vld_next  = m_vld_reg;
        m_data_next = m_data_reg;
        m_user_next = m_user_reg;
        w_next      = w_reg;
        start_next  = start_reg;
        iss_next    = iss_reg;
        first_next  = first_reg;
        xref_next   = xref_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        sxx_next    = sxx_reg;
        sxy_next    = sxy_reg;
        sel_next    = sel_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        macc_next   = macc_reg;
        t_next      = t_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        slope_next  = slope_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        rd_vld_next = 1'b0;
        cnt_nx_e    = '0;
        sat         = 1'b0;
        mag48       = '0;

        idx_e  = EW'(s_tdata[59:48]);
        lim_e  = EW'(s_tdata[72:60]);
        wl_e   = EW'(s_tdata[85:73]);
        cnt_e  = EW'(count_reg);
        n_e    = (cnt_e < lim_e) ? cnt_e : lim_e;
        w_e    = (wl_e < cnt_e) ? wl_e : cnt_e;
        lin_e  = (cmd == CMD_RECENT) ? cnt_e - n_e + idx_e : idx_e;
        lin    = (state_reg == ST_WALK) ? start_reg + iss_reg : lin_e[CW-1:0];
        num_v  = t_reg - macc_reg;
        mag    = num_v[WW-1] ? ~num_v + WW'(1) : num_v;
        rem_sh = {rem_reg, dvd_reg[QW-1]};
        ge     = rem_sh >= {1'b0, den_reg};

        // walk pipeline: RAM data, x and y, products, sums
        rd_cyc      = ram_rdata[47:16];
        xr          = first_reg ? rd_cyc : xref_reg;
        x_a         = $signed({1'b0, rd_cyc}) - $signed({1'b0, xr});
        b_vld_next  = rd_vld_reg;
        bx_next     = x_a;
        bax_next    = x_a[32] ? 32'(-x_a) : x_a[31:0];
        by_next     = ram_rdata[15:0];
        c_vld_next  = b_vld_reg;
        cx_next     = bx_reg;
        cy_next     = by_reg;
        pxx_next    = bax_reg * bax_reg;
        pxy_next    = bx_reg * $signed({1'b0, by_reg});
        if (rd_vld_reg && first_reg) begin
            xref_next  = rd_cyc;
            first_next = 1'b0;
        end
        if (c_vld_reg) begin
            sx_next  = sx_reg + SXW'(cx_reg);
            sy_next  = sy_reg + SYW'(cy_reg);
            sxx_next = sxx_reg + SXXW'(pxx_reg);
            sxy_next = sxy_reg + SXYW'(pxy_reg);
        end

        if (p1_go) begin
            p1_vld_next = 1'b0;
            m_vld_next  = 1'b1;
            m_data_next = {(M_DATA_W - 122)'(0), SLOPE_W'(0), p1_rc_reg, p1_cnt_reg,
                           p1_rd_reg ? ram_rdata : 48'd0};
            m_user_next = p1_rd_reg;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    p1_vld_next = 1'b1;
                    p1_rd_next  = 1'b0;
                    p1_rc_next  = '0;
                    case (cmd)
                        CMD_RECORD: begin
                            if (enable_reg) begin
                                ram_we    = 1'b1;
                                wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0
                                            : wptr_reg + AW'(1);
                                if (count_reg < CW'(DEPTH)) begin
                                    count_next = count_reg + CW'(1);
                                end
                            end
                        end
                        CMD_READ: begin
                            ram_re     = 1'b1;
                            p1_rd_next = idx_e < cnt_e;
                        end
                        CMD_RECENT: begin
                            ram_re     = 1'b1;
                            p1_rd_next = idx_e < n_e;
                            p1_rc_next = n_e[FIELD_W-1:0];
                        end
                        CMD_SLOPE: begin
                            p1_vld_next = 1'b0;
                            if (w_e < EW'(2)) begin
                                slope_next = '0;
                                state_next = ST_DONE;
                            end else begin
                                w_next     = w_e[CW-1:0];
                                start_next = count_reg - w_e[CW-1:0];
                                iss_next   = '0;
                                first_next = 1'b1;
                                sx_next    = '0;
                                sy_next    = '0;
                                sxx_next   = '0;
                                sxy_next   = '0;
                                state_next = ST_WALK;
                            end
                        end
                        CMD_CLEAR: begin
                            wptr_next  = '0;
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                    cnt_nx_e    = EW'(count_next);
                    p1_cnt_next = cnt_nx_e[FIELD_W-1:0];
                end
            end
            ST_WALK: begin
                if (iss_reg < w_reg) begin
                    ram_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    iss_next    = iss_reg + CW'(1);
                end else if (!rd_vld_reg && !b_vld_reg && !c_vld_reg) begin
                    sel_next   = 2'd0;
                    ma_next    = opa;
                    mb_next    = opb;
                    macc_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mb_reg == '0) begin
                    case (sel_reg)
                        2'd0: t_next = macc_reg;
                        2'd1: den_next = t_reg - macc_reg;
                        2'd2: t_next = macc_reg;
                        default: begin
                        end
                    endcase
                    if (sel_reg == 2'd3) begin
                        if (den_reg[WW-1] || den_reg == '0) begin
                            slope_next = '0;
                            state_next = ST_DONE;
                        end else begin
                            neg_next   = num_v[WW-1];
                            dvd_next   = {mag, FRAC_W'(0)};
                            rem_next   = '0;
                            dcnt_next  = DCW'(QW);
                            state_next = ST_DIV;
                        end
                    end else begin
                        sel_next  = sel_ld;
                        ma_next   = opa;
                        mb_next   = opb;
                        macc_next = '0;
                    end
                end else begin
                    if (mb_reg[0]) begin
                        macc_next = macc_reg + ma_reg;
                    end
                    ma_next = {ma_reg[WW-2:0], 1'b0};
                    mb_next = {1'b0, mb_reg[WW-1:1]};
                end
            end
            ST_DIV: begin
                if (dcnt_reg != '0) begin
                    rem_next  = ge ? WW'(rem_sh - {1'b0, den_reg}) : rem_sh[WW-1:0];
                    dvd_next  = {dvd_reg[QW-2:0], ge};
                    dcnt_next = dcnt_reg - DCW'(1);
                end else begin
                    // saturate the quotient to signed Q15.32
                    if (neg_reg) begin
                        sat = (|dvd_reg[QW-1:SLOPE_W]) ||
                              (dvd_reg[SLOPE_W-1] && (|dvd_reg[SLOPE_W-2:0]));
                        mag48 = sat ? {1'b1, (SLOPE_W - 1)'(0)} : dvd_reg[SLOPE_W-1:0];
                        slope_next = ~mag48 + SLOPE_W'(1);
                    end else begin
                        sat = (|dvd_reg[QW-1:SLOPE_W]) || dvd_reg[SLOPE_W-1];
                        slope_next = sat ? {1'b0, {(SLOPE_W - 1){1'b1}}}
                                         : dvd_reg[SLOPE_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cnt_nx_e    = EW'(count_reg);
                    m_vld_next  = 1'b1;
                    m_data_next = {(M_DATA_W - 122)'(0), slope_reg, FIELD_W'(0),
                                   cnt_nx_e[FIELD_W-1:0], 48'd0};
                    m_user_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid) begin
            enable_next = cfg_data[0];
            if (!cfg_data[0]) begin
                wptr_next  = '0;
                count_next = '0;
            end
        end
    end

endmodule

/* rtl/trs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module trs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/trs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks on the result channel of the trace ring.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trs_checker #(
    parameter int DEPTH = 4096
) (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [0:0]   m_tuser
);

    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `ASSERT_IMPLY(a_count_bound, aclk, aresetn, m_tvalid,
                  {19'd0, m_tdata[60:48]} <= 32'(DEPTH))
    `ASSERT_IMPLY(a_invalid_zero, aclk, aresetn, m_tvalid && !m_tuser[0],
                  m_tdata[47:0] == 48'd0)
    `ASSERT_IMPLY(a_slope_alone, aclk, aresetn, m_tvalid && (m_tdata[121:74] != 48'd0),
                  !m_tuser[0] && (m_tdata[73:61] == 13'd0))

endmodule

bind trace_ring_with_slope trs_checker #(.DEPTH(DEPTH)) u_trs_checker (.*);

/* verif/trace_ring_with_slope_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_ring_with_slope_checker
// Watches the command, result and enable channels of the trace ring, keeps
// its own copy of the sample ring, predicts each result and compares it.
// ----------------------------------------------------------------------------
module trace_ring_with_slope_checker #(
    parameter int DEPTH = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [trs_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [trs_pkg::S_USER_W-1:0]  s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [trs_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic [trs_pkg::M_USER_W-1:0]  m_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [0:0]                    cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            result_count
);
    import trs_pkg::*;

    typedef struct {
        logic [15:0] sp;
        logic [31:0] cycles;
        logic        valid;
        logic [12:0] stored;
        logic [12:0] recent;
        logic [47:0] slope;
    } ring_result_t;

    logic [15:0] ring_sp [DEPTH];
    logic [31:0] ring_cy [DEPTH];
    int unsigned wr_ptr;
    int unsigned fill;
    logic        rec_on;
    ring_result_t expected_results[$];

    function automatic int unsigned slot_of(int unsigned lin);
        if (fill < DEPTH) begin
            return lin % DEPTH;
        end
        return (wr_ptr + lin) % DEPTH;
    endfunction

    function automatic logic [127:0] wide(longint v);
        return {{64{v[63]}}, v};
    endfunction

    // Least-squares fit of sp against stamps relative to the window's first
    // sample; Q15.32, truncated toward zero, saturated to 48 bits.
    function automatic logic [47:0] fit_slope(int unsigned wlen);
        int unsigned w;
        int unsigned first;
        longint xref;
        longint x;
        longint y;
        longint sx;
        longint sy;
        logic signed [127:0] sxx;
        logic signed [127:0] sxy;
        logic signed [127:0] den;
        logic signed [127:0] num;
        logic [127:0] mag;
        logic [127:0] quo;
        logic neg;
        w = (wlen > fill) ? fill : wlen;
        if (w < 2) begin
            return '0;
        end
        first = fill - w;
        xref = longint'({32'b0, ring_cy[slot_of(first)]});
        sx = 0;
        sy = 0;
        sxx = '0;
        sxy = '0;
        for (int unsigned i = 0; i < w; i++) begin
            x = longint'({32'b0, ring_cy[slot_of(first + i)]}) - xref;
            y = longint'({48'b0, ring_sp[slot_of(first + i)]});
            sx += x;
            sy += y;
            sxx += $signed(wide(x)) * $signed(wide(x));
            sxy += $signed(wide(x * y));
        end
        den = $signed(wide(longint'(w))) * sxx - $signed(wide(sx)) * $signed(wide(sx));
        if (den <= 0) begin
            return '0;
        end
        num = $signed(wide(longint'(w))) * sxy - $signed(wide(sx)) * $signed(wide(sy));
        neg = num[127];
        mag = neg ? -num : num;
        quo = (mag << 32) / den;
        if (neg) begin
            if (quo > 128'h8000_0000_0000) begin
                quo = 128'h8000_0000_0000;
            end
            return 48'(-quo);
        end
        if (quo > 128'h7FFF_FFFF_FFFF) begin
            quo = 128'h7FFF_FFFF_FFFF;
        end
        return quo[47:0];
    endfunction

    function automatic ring_result_t predict_ring(logic [2:0] cmd, logic [87:0] d);
        ring_result_t r;
        int unsigned idx;
        int unsigned lim;
        int unsigned n;
        idx = d[59:48];
        lim = d[72:60];
        r = '{default: '0};
        case (cmd)
            CMD_RECORD: begin
                if (rec_on) begin
                    ring_sp[wr_ptr] = d[15:0];
                    ring_cy[wr_ptr] = d[47:16];
                    wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
                    if (fill < DEPTH) begin
                        fill++;
                    end
                end
            end
            CMD_READ: begin
                if (idx < fill) begin
                    r.sp = ring_sp[slot_of(idx)];
                    r.cycles = ring_cy[slot_of(idx)];
                    r.valid = 1'b1;
                end
            end
            CMD_RECENT: begin
                n = (fill < lim) ? fill : lim;
                r.recent = 13'(n);
                if (idx < n) begin
                    r.sp = ring_sp[slot_of(fill - n + idx)];
                    r.cycles = ring_cy[slot_of(fill - n + idx)];
                    r.valid = 1'b1;
                end
            end
            CMD_SLOPE: r.slope = fit_slope(d[85:73]);
            CMD_CLEAR: begin
                wr_ptr = 0;
                fill = 0;
            end
            default: ;
        endcase
        r.stored = 13'(fill);
        return r;
    endfunction

    always @(posedge aclk) begin
        ring_result_t e;
        ring_result_t a;
        if (!aresetn) begin
            wr_ptr = 0;
            fill = 0;
            rec_on = 1'b0;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
            result_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                rec_on = cfg_data[0];
                if (!rec_on) begin
                    wr_ptr = 0;
                    fill = 0;
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_ring(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready) begin
                result_count++;
                a.sp = m_tdata[15:0];
                a.cycles = m_tdata[47:16];
                a.stored = m_tdata[60:48];
                a.recent = m_tdata[73:61];
                a.slope = m_tdata[121:74];
                a.valid = m_tuser[0];
                if (expected_results.size() == 0) begin
                    $error("result with no item waiting");
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (a.sp !== e.sp) begin
                        $error("sample_sp expected %0h got %0h", e.sp, a.sp);
                        fail_count++;
                    end
                    if (a.cycles !== e.cycles) begin
                        $error("sample_cycles expected %0h got %0h", e.cycles, a.cycles);
                        fail_count++;
                    end
                    if (a.valid !== e.valid) begin
                        $error("sample_valid expected %0b got %0b", e.valid, a.valid);
                        fail_count++;
                    end
                    if (a.stored !== e.stored) begin
                        $error("stored_count expected %0d got %0d", e.stored, a.stored);
                        fail_count++;
                    end
                    if (a.recent !== e.recent) begin
                        $error("recent_count expected %0d got %0d", e.recent, a.recent);
                        fail_count++;
                    end
                    if (a.slope !== e.slope) begin
                        $error("slope expected %0h got %0h", e.slope, a.slope);
                        fail_count++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

/* verif/trace_ring_with_slope_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_ring_with_slope_test
// Drives directed and random record, read, recent, slope, clear and undefined
// command items into the trace ring under varying back-pressure; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module trace_ring_with_slope_test;
    import trs_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [S_USER_W-1:0]  s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [M_USER_W-1:0]  m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [0:0]           cfg_data;
    int                   fail_count;
    int                   pending;
    int                   result_count;

    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        hold_req;
    int          hold_left;
    int          item_count;
    int unsigned shadow_fill;
    logic        shadow_on;
    logic [31:0] stamp_now;
    logic [15:0] sp_now;

    trace_ring_with_slope u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    trace_ring_with_slope_checker u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    always #5 aclk = ~aclk;

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #30ms;
        $display("Verification failed");
        $finish;
    end

    // Leave tvalid high after acceptance; the next item replaces the payload or an idle drops it.
    task automatic send_item(logic [2:0] cmd, logic [15:0] sp, logic [31:0] stamp,
                             logic [11:0] idx, logic [12:0] lim, logic [12:0] wlen);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b0, wlen, lim, idx, stamp, sp};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        item_count++;
        if (cmd == CMD_RECORD && shadow_on && shadow_fill < 4096) begin
            shadow_fill++;
        end
        if (cmd == CMD_CLEAR) begin
            shadow_fill = 0;
        end
    endtask

    task automatic write_enable(logic val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        shadow_on = val;
        if (!val) begin
            shadow_fill = 0;
        end
    endtask

    // Record mostly a plausible trace: rising stamps, drifting stack pointer.
    task automatic random_item();
        int unsigned pick;
        logic [2:0]  cmd;
        logic [11:0] idx;
        logic [12:0] lim;
        logic [12:0] wlen;
        logic [15:0] sp;
        logic [31:0] stamp;
        pick = $urandom_range(99);
        stamp_now += $urandom_range(40);
        sp_now += 16'($urandom_range(8)) - 16'd4;
        sp = ($urandom_range(9) == 0) ? 16'($urandom) : sp_now;
        stamp = ($urandom_range(9) == 0) ? $urandom : stamp_now;
        idx = ($urandom_range(4) == 0) ? 12'($urandom) : 12'($urandom_range(shadow_fill + 2));
        lim = ($urandom_range(4) == 0) ? 13'($urandom) : 13'($urandom_range(shadow_fill + 2));
        if ($urandom_range(29) == 0) begin
            wlen = 13'($urandom);
        end else begin
            wlen = 13'($urandom_range(20));
        end
        if (pick < 45) cmd = CMD_RECORD;
        else if (pick < 65) cmd = CMD_READ;
        else if (pick < 82) cmd = CMD_RECENT;
        else if (pick < 95) cmd = CMD_SLOPE;
        else if (pick < 97) cmd = CMD_CLEAR;
        else cmd = 3'($urandom_range(7, 5));
        send_item(cmd, sp, stamp, idx, lim, wlen);
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hold_req = 1'b0;
        hold_left = 0;
        tx_idle_pct = 10;
        rx_idle_pct = 70;
        item_count = 0;
        shadow_fill = 0;
        shadow_on = 1'b0;
        stamp_now = 32'd1000;
        sp_now = 16'h8000;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: disabled record, extremes, every command, corner cases.
        write_enable(1'b0);
        send_item(CMD_RECORD, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF, 13'h1FFF, 13'h1FFF);
        send_item(CMD_READ, 16'h0, 32'h0, 12'h0, 13'h0, 13'h0);
        write_enable(1'b1);
        send_item(CMD_SLOPE, 16'h0, 32'h0, 12'h0, 13'h0, 13'd4096);
        send_item(CMD_RECORD, 16'hFFFF, 32'hFFFF_FFFF, 12'h0, 13'h0, 13'h0);
        send_item(CMD_SLOPE, 16'h0, 32'h0, 12'h0, 13'h0, 13'd2);
        send_item(CMD_RECORD, 16'h0000, 32'h0000_0000, 12'h0, 13'h0, 13'h0);
        send_item(CMD_SLOPE, 16'h0, 32'h0, 12'h0, 13'h0, 13'd2);
        send_item(CMD_RECORD, 16'hFFFF, 32'h0000_0001, 12'h0, 13'h0, 13'h0);
        send_item(CMD_SLOPE, 16'h0, 32'h0, 12'h0, 13'h0, 13'h1FFF);
        send_item(CMD_READ, 16'h0, 32'h0, 12'd2, 13'h0, 13'h0);
        send_item(CMD_READ, 16'h0, 32'h0, 12'd3, 13'h0, 13'h0);
        send_item(CMD_RECENT, 16'h0, 32'h0, 12'd0, 13'd0, 13'h0);
        send_item(CMD_RECENT, 16'h0, 32'h0, 12'd1, 13'd2, 13'h0);
        send_item(CMD_RECENT, 16'h0, 32'h0, 12'hFFF, 13'h1FFF, 13'h0);
        send_item(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF, 13'h1FFF, 13'h1FFF);
        send_item(CMD_CLEAR, 16'h0, 32'h0, 12'h0, 13'h0, 13'h0);
        // Equal stamps give a zero denominator.
        repeat (3) send_item(CMD_RECORD, 16'($urandom), 32'd77, 12'h0, 13'h0, 13'h0);
        send_item(CMD_SLOPE, 16'h0, 32'h0, 12'h0, 13'h0, 13'd3);
        // Steep rise saturates positive; a third, earlier-stamped sample stays unsaturated.
        send_item(CMD_CLEAR, 16'h0, 32'h0, 12'h0, 13'h0, 13'h0);
        send_item(CMD_RECORD, 16'h0, 32'd5, 12'h0, 13'h0, 13'h0);
        send_item(CMD_RECORD, 16'hFFFF, 32'd6, 12'h0, 13'h0, 13'h0);
        send_item(CMD_SLOPE, 16'h0, 32'h0, 12'h0, 13'h0, 13'd2);
        send_item(CMD_RECORD, 16'h0, 32'd4, 12'h0, 13'h0, 13'h0);
        send_item(CMD_SLOPE, 16'h0, 32'h0, 12'h0, 13'h0, 13'd2);

        repeat (300) random_item();
        write_enable(1'b0);
        write_enable(1'b1);
        tx_idle_pct = 70;
        rx_idle_pct = 10;
        repeat (300) random_item();

        // Record a long burst while the receiver holds off for a while.
        write_enable(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        for (int i = 0; i < 400; i++) begin
            stamp_now += $urandom_range(40);
            send_item(CMD_RECORD, 16'($urandom), stamp_now, 12'h0, 13'h0, 13'h0);
        end
        send_item(CMD_SLOPE, 16'h0, 32'h0, 12'h0, 13'h0, 13'd4096);
        send_item(CMD_READ, 16'h0, 32'h0, 12'hFFF, 13'h0, 13'h0);
        send_item(CMD_RECENT, 16'h0, 32'h0, 12'hFFF, 13'd4096, 13'h0);
        repeat (100) random_item();
        write_enable(1'b0);
        repeat (20) random_item();

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Sent %0d items (all commands, long record burst, enable toggled)",
                 item_count);
        $display("Checked %0d results under random and long receiver stalls", result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/trs_pkg.sv
rtl/trs_ram.sv
rtl/trace_ring_with_slope.sv
rtl/trs_checker.sv
verif/trace_ring_with_slope_checker.sv
verif/trace_ring_with_slope_test.sv
